// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 64;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
    localparam logic               REQ_GET   = 1'b0;
    localparam logic               REQ_PUT   = 1'b1;
    localparam logic [VAL_W-1:0]   RD_MISS   = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_NEW = 32'd1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic clear;
        logic scan;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;
    } t_dp_sts;

endpackage

// ===== rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps

module lfu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lfu_pkg::t_dp_sts i_sts,
    output lfu_pkg::t_dp_cmd o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_busy         = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && r_state == ST_SCAN))
        else $error("accepted request did not start a scan");
`endif

endmodule

// ===== rtl/lfu_datapath.sv =====
`timescale 1ns / 1ps

module lfu_datapath #(
    parameter int CACHE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lfu_pkg::t_dp_cmd           i_cmd,
    output lfu_pkg::t_dp_sts           o_sts,
    input  logic                       i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_req_type,
    input  logic [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic [lfu_pkg::VAL_W-1:0]  i_value_in,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [lfu_pkg::VAL_W-1:0]  o_read_value,
    output logic                       o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]  o_evicted_key
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int UW = $clog2(CACHE_DEPTH + 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CACHE_DEPTH - 1);
    localparam logic [UW-1:0] USED_ALL  = UW'(CACHE_DEPTH);

    lfu_pkg::t_entry mem [0:CACHE_DEPTH-1];
    lfu_pkg::t_entry r_rd_data;

    logic [lfu_pkg::CFG_W-1:0]   r_cap;
    logic [AW-1:0]               r_addr;
    logic                        r_rd_vld;
    logic [AW-1:0]               r_rd_idx;
    logic [lfu_pkg::STAMP_W-1:0] r_clock;

    logic                        r_req_type;
    logic [lfu_pkg::KEY_W-1:0]   r_key;
    logic [lfu_pkg::VAL_W-1:0]   r_val;

    logic [UW-1:0]               r_used;
    logic                        r_found_v;
    logic [AW-1:0]               r_found_idx;
    logic [lfu_pkg::VAL_W-1:0]   r_found_val;
    logic [lfu_pkg::COUNT_W-1:0] r_found_cnt;
    logic                        r_free_v;
    logic [AW-1:0]               r_free_idx;
    logic                        r_vic_v;
    logic [AW-1:0]               r_vic_idx;
    logic [lfu_pkg::KEY_W-1:0]   r_vic_key;
    logic [lfu_pkg::COUNT_W-1:0] r_vic_cnt;
    logic [lfu_pkg::STAMP_W-1:0] r_vic_stamp;

    logic                        r_done;
    logic                        r_hit;
    logic [lfu_pkg::VAL_W-1:0]   r_rd_value;
    logic                        r_evicted;
    logic [lfu_pkg::KEY_W-1:0]   r_ev_key;

    logic                        n_we;
    logic [AW-1:0]               n_waddr;
    lfu_pkg::t_entry             n_wdata;
    logic                        n_clock_adv;
    logic                        n_evict;
    logic [lfu_pkg::COUNT_W-1:0] bump_cnt;
    logic [lfu_pkg::STAMP_W-1:0] new_stamp;
    logic                        full;
    logic                        cap_nz;
    logic                        vic_better;

    assign o_sts.addr_last = (r_addr == ADDR_LAST);

    assign bump_cnt  = (r_found_cnt == lfu_pkg::COUNT_MAX) ? r_found_cnt
                                                            : r_found_cnt + 1'b1;
    assign new_stamp = r_clock + 1'b1;
    assign cap_nz    = (r_cap != '0);
    assign full      = (r_used == USED_ALL) ||
                       ({{(32 - UW){1'b0}}, r_used} >=
                        {{(32 - lfu_pkg::CFG_W){1'b0}}, r_cap});
    assign vic_better = !r_vic_v || (r_rd_data.count < r_vic_cnt) ||
                        ((r_rd_data.count == r_vic_cnt) && (r_rd_data.stamp < r_vic_stamp));

    always_comb begin
        n_we        = 1'b0;
        n_waddr     = r_addr;
        n_wdata     = '0;
        n_clock_adv = 1'b0;
        n_evict     = 1'b0;
        if (i_cmd.clear) begin
            n_we = 1'b1;
        end else if (i_cmd.update) begin
            n_wdata.valid = 1'b1;
            n_wdata.key   = r_key;
            n_wdata.stamp = new_stamp;
            if (r_found_v) begin
                n_waddr       = r_found_idx;
                n_wdata.count = bump_cnt;
                if (r_req_type == lfu_pkg::REQ_GET) begin
                    n_wdata.value = r_found_val;
                    n_we          = 1'b1;
                end else begin
                    n_wdata.value = r_val;
                    n_we          = cap_nz;
                end
            end else if ((r_req_type == lfu_pkg::REQ_PUT) && cap_nz) begin
                n_wdata.value = r_val;
                n_wdata.count = lfu_pkg::COUNT_NEW;
                n_we          = 1'b1;
                if (full) begin
                    n_evict = 1'b1;
                    n_waddr = r_vic_idx;
                end else begin
                    n_waddr = r_free_idx;
                end
            end
            n_clock_adv = n_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_waddr] <= n_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= lfu_pkg::CAP_RESET;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_clock  <= '0;
            r_done   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.capture) begin
                r_addr <= '0;
            end else if (i_cmd.clear || i_cmd.scan) begin
                r_addr <= r_addr + 1'b1;
            end
            r_rd_vld <= i_cmd.scan;
            if (n_clock_adv) begin
                r_clock <= new_stamp;
            end
            r_done <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_key      <= i_key;
            r_val      <= i_value_in;
            r_used     <= '0;
            r_found_v  <= 1'b0;
            r_free_v   <= 1'b0;
            r_vic_v    <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_data.valid) begin
                r_used <= r_used + 1'b1;
                if (!r_found_v && (r_rd_data.key == r_key)) begin
                    r_found_v   <= 1'b1;
                    r_found_idx <= r_rd_idx;
                    r_found_val <= r_rd_data.value;
                    r_found_cnt <= r_rd_data.count;
                end
                if (vic_better) begin
                    r_vic_v     <= 1'b1;
                    r_vic_idx   <= r_rd_idx;
                    r_vic_key   <= r_rd_data.key;
                    r_vic_cnt   <= r_rd_data.count;
                    r_vic_stamp <= r_rd_data.stamp;
                end
            end else if (!r_free_v) begin
                r_free_v   <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        if (i_cmd.update) begin
            r_hit      <= r_found_v;
            r_rd_value <= (r_found_v && (r_req_type == lfu_pkg::REQ_GET)) ? r_found_val
                                                                         : lfu_pkg::RD_MISS;
            r_evicted  <= n_evict;
            r_ev_key   <= n_evict ? r_vic_key : '0;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = r_rd_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_ev_key;

`ifndef NO_ASSERTIONS
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_evicted) |-> (!r_hit && r_req_type == lfu_pkg::REQ_PUT))
        else $error("eviction on a hit or on a get");
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_hit) |-> (r_rd_value == lfu_pkg::RD_MISS))
        else $error("miss returned a stored value");
    a_evict_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && n_evict) |-> (r_vic_v && r_used != '0))
        else $error("eviction without a valid victim");
`endif

endmodule

// ===== rtl/lfu_cache_replacement.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals                                  Handshake
// request   in         i_req_type, i_key, i_value_in            i_start && !o_busy
// result    out        o_hit, o_read_value, o_evicted,          o_done, one cycle
//                      o_evicted_key
// config    in         i_cfg_wdata (cache_capacity)             i_cfg_we
//
// A request holds o_busy high through the scan, drain and write-back states:
// one entry read per cycle, then a drain of the read register, then the write back.
// o_done marks the result in the first cycle with o_busy low; a new request may be
// taken in that cycle. The receiver cannot stall results. After reset a clearing
// pass invalidates every entry with o_busy high; configuration writes are still taken.
module lfu_cache_replacement #(
    parameter int CACHE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_req_type,
    input  logic signed [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lfu_pkg::VAL_W-1:0]  i_value_in,
    input  logic                              i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                              o_done,
    output logic                              o_hit,
    output logic signed [lfu_pkg::VAL_W-1:0]  o_read_value,
    output logic                              o_evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]  o_evicted_key
);

    lfu_pkg::t_dp_cmd cmd;
    lfu_pkg::t_dp_sts sts;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    lfu_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH          = 16;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 155;
    localparam int POOL_SIZE      = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_W       = lfu_pkg::KEY_W;

    typedef struct packed {
        logic                      hit;
        logic [lfu_pkg::VAL_W-1:0] read_value;
        logic                      evicted;
        logic [lfu_pkg::KEY_W-1:0] evicted_key;
    } t_lookup_result;

    typedef struct {
        bit             typed;
        t_lookup_result want;
    } t_typed_answer;

    typedef struct {
        int                        new_cap;
        logic                      req;
        logic [lfu_pkg::KEY_W-1:0] key;
        logic [lfu_pkg::VAL_W-1:0] value;
        bit                        typed;
        logic                      hit;
        logic [lfu_pkg::VAL_W-1:0] rd;
    } t_directed_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_start;
    logic                              o_busy;
    logic                              i_req_type;
    logic signed [lfu_pkg::KEY_W-1:0]  i_key;
    logic signed [lfu_pkg::VAL_W-1:0]  i_value_in;
    logic                              i_cfg_we;
    logic [lfu_pkg::CFG_W-1:0]         i_cfg_wdata;
    logic                              o_done;
    logic                              o_hit;
    logic signed [lfu_pkg::VAL_W-1:0]  o_read_value;
    logic                              o_evicted;
    logic signed [lfu_pkg::KEY_W-1:0]  o_evicted_key;

    lfu_cache_replacement #(
        .CACHE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value_in   (i_value_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted),
        .o_evicted_key(o_evicted_key)
    );

    always #4 i_clk = ~i_clk;

    logic                        slot_valid [DEPTH];
    logic [lfu_pkg::KEY_W-1:0]   slot_key   [DEPTH];
    logic [lfu_pkg::VAL_W-1:0]   slot_value [DEPTH];
    logic [lfu_pkg::COUNT_W-1:0] slot_count [DEPTH];
    logic [lfu_pkg::STAMP_W-1:0] slot_stamp [DEPTH];
    logic [lfu_pkg::STAMP_W-1:0] touch_clock;
    logic [lfu_pkg::CFG_W-1:0]   model_capacity;

    t_lookup_result  pending_responses [$];
    t_typed_answer   row_answers [$];
    t_directed_row   directed_rows [$];
    int              mismatch_count = 0;
    int              stall_cycles = 0;

    task automatic compute_cache_response(input logic req,
                                          input logic [lfu_pkg::KEY_W-1:0] key,
                                          input logic [lfu_pkg::VAL_W-1:0] value,
                                          output t_lookup_result r);
        int limit;
        int used;
        int found;
        int free_slot;
        int victim;
        int slot;
        limit = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
        used = 0;
        found = -1;
        free_slot = -1;
        victim = -1;
        r.hit = 1'b0;
        r.read_value = lfu_pkg::RD_MISS;
        r.evicted = 1'b0;
        r.evicted_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (found < 0 && slot_key[i] == key)
                    found = i;
                if (victim < 0 || slot_count[i] < slot_count[victim] ||
                    (slot_count[i] == slot_count[victim] &&
                     slot_stamp[i] < slot_stamp[victim]))
                    victim = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        r.hit = (found >= 0);
        if (found >= 0 && (req == lfu_pkg::REQ_GET || limit != 0)) begin
            if (req == lfu_pkg::REQ_GET)
                r.read_value = slot_value[found];
            else
                slot_value[found] = value;
            if (slot_count[found] != lfu_pkg::COUNT_MAX)
                slot_count[found] = slot_count[found] + 1'b1;
            touch_clock = touch_clock + 1'b1;
            slot_stamp[found] = touch_clock;
        end else if (found < 0 && req == lfu_pkg::REQ_PUT && limit != 0) begin
            slot = free_slot;
            if (used >= limit && victim >= 0) begin
                r.evicted = 1'b1;
                r.evicted_key = slot_key[victim];
                slot = victim;
            end
            if (slot >= 0) begin
                slot_valid[slot] = 1'b1;
                slot_key[slot] = key;
                slot_value[slot] = value;
                slot_count[slot] = lfu_pkg::COUNT_NEW;
                touch_clock = touch_clock + 1'b1;
                slot_stamp[slot] = touch_clock;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [REPORT_W-1:0] got,
                                   input logic [REPORT_W-1:0] want);
        $display("%0t ns: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : response_check
        t_lookup_result got;
        t_lookup_result want;
        t_typed_answer  ans;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_count[i] = '0;
                slot_stamp[i] = '0;
            end
            touch_clock = '0;
            model_capacity = lfu_pkg::CAP_RESET;
        end else begin
            if (o_done) begin
                got = {o_hit, o_read_value, o_evicted, o_evicted_key};
                if (pending_responses.size() == 0) begin
                    report_mismatch("result with no request, evicted_key", got.evicted_key, '0);
                end else begin
                    want = pending_responses.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", REPORT_W'(got.hit), REPORT_W'(want.hit));
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", REPORT_W'(got.evicted),
                                        REPORT_W'(want.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
                end
            end
            if (i_cfg_we)
                model_capacity = i_cfg_wdata;
            if (i_start && !o_busy) begin
                compute_cache_response(i_req_type, i_key, i_value_in, want);
                if (row_answers.size() != 0) begin
                    ans = row_answers.pop_front();
                    if (ans.typed)
                        want = ans.want;
                end
                pending_responses.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("lfu_cache_replacement test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_row(input int new_cap, input logic req,
                           input logic [lfu_pkg::KEY_W-1:0] key,
                           input logic [lfu_pkg::VAL_W-1:0] value, input bit typed,
                           input logic hit, input logic [lfu_pkg::VAL_W-1:0] rd);
        t_directed_row r;
        r.new_cap = new_cap;
        r.req = req;
        r.key = key;
        r.value = value;
        r.typed = typed;
        r.hit = hit;
        r.rd = rd;
        directed_rows.push_back(r);
    endtask

    task automatic send_request(input logic req, input logic [lfu_pkg::KEY_W-1:0] key,
                                input logic [lfu_pkg::VAL_W-1:0] value, input bit typed,
                                input logic hit, input logic [lfu_pkg::VAL_W-1:0] rd,
                                input int gap);
        t_typed_answer ans;
        ans.typed = typed;
        ans.want.hit = hit;
        ans.want.read_value = rd;
        ans.want.evicted = 1'b0;
        ans.want.evicted_key = '0;
        if (gap > 0) begin
            @(negedge i_clk) i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        row_answers.push_back(ans);
        i_req_type = req;
        i_key = key;
        i_value_in = value;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic drain_responses();
        @(negedge i_clk) i_start = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CFG_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk) i_cfg_we = 1'b0;
    endtask

    initial begin : stimulus
        logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [lfu_pkg::CFG_W-1:0] cap;
        logic                      req;
        logic [lfu_pkg::KEY_W-1:0] key;
        logic [lfu_pkg::VAL_W-1:0] value;
        int                        pool_n;
        int                        gap;
        int                        pick;
        bit                        idle_on;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = lfu_pkg::REQ_GET;
        i_key = '0;
        i_value_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // reset capacity: fill, read back, overwrite in place
        add_row(-1, lfu_pkg::REQ_GET, 32'h0000_0000, 32'h1234_5678, 1, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'h8000_0000);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b1, 32'h7FFF_FFFF);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF);
        // capacity below occupancy: evict and reuse the slot
        add_row(2, lfu_pkg::REQ_PUT, 32'h0000_0001, 32'h0000_0011, 0, 1'b0, lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h0000_0002, 32'h0000_0022, 0, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000, 0, 1'b0,
                lfu_pkg::RD_MISS);
        // zero capacity: puts leave the cache untouched
        add_row(0, lfu_pkg::REQ_PUT, 32'h0000_0003, 32'h0000_0033, 1, 1'b0, lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h0000_0002, 32'h0000_0099, 0, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'h0000_0002, 32'h0000_0000, 0, 1'b0,
                lfu_pkg::RD_MISS);
        // capacity above depth
        add_row(31, lfu_pkg::REQ_PUT, 32'h0000_0004, 32'h0000_0044, 0, 1'b0,
                lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_GET, 32'h0000_0004, 32'h0000_0000, 0, 1'b0,
                lfu_pkg::RD_MISS);
        // single entry
        add_row(1, lfu_pkg::REQ_PUT, 32'h0000_0005, 32'h0000_0055, 0, 1'b0, lfu_pkg::RD_MISS);
        add_row(-1, lfu_pkg::REQ_PUT, 32'h0000_0006, 32'h0000_0066, 0, 1'b0,
                lfu_pkg::RD_MISS);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].new_cap >= 0) begin
                drain_responses();
                write_capacity(directed_rows[i].new_cap[lfu_pkg::CFG_W-1:0]);
            end
            send_request(directed_rows[i].req, directed_rows[i].key, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].hit, directed_rows[i].rd, 0);
        end

        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: cap = 5'd31;
                1: cap = 5'd0;
                2: cap = 5'd1;
                3: cap = 5'd3;
                4: cap = 5'd16;
                5: cap = 5'd2;
                6: cap = 5'd17;
                8: cap = 5'd0;
                9: cap = 5'd8;
                11: cap = 5'd16;
                default: begin
                    pick = $urandom_range(0, 31);
                    cap = pick[lfu_pkg::CFG_W-1:0];
                end
            endcase
            drain_responses();
            write_capacity(cap);
            pool_n = $urandom_range(2, POOL_SIZE);
            for (int i = 2; i < POOL_SIZE; i++)
                if ($urandom_range(0, 1) != 0)
                    key_pool[i] = $urandom;
            idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req = ($urandom_range(0, 1) != 0) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET;
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    key = $urandom;
                value = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    value = '0;
                else if (pick < 6)
                    value = '1;
                gap = 0;
                pick = $urandom_range(0, 99);
                if (idle_on && pick >= 95)
                    gap = $urandom_range(10, 60);
                else if (idle_on && pick >= 70)
                    gap = $urandom_range(1, 3);
                if ($urandom_range(0, 199) == 0)
                    drain_responses();
                send_request(req, key, value, 0, 1'b0, lfu_pkg::RD_MISS, gap);
            end
        end

        drain_responses();
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("lfu_cache_replacement test passed");
        end else begin
            $display("lfu_cache_replacement test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_replacement.sv
dv/tb.sv
